// ----- rtl/core/rmbpp_pkg.sv -----
`timescale 1ns / 1ps

package rmbpp_pkg;

	// Framing phase, one-hot
	typedef enum logic [3:0] {
		PH_WAIT   = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_ERR_C2 = 4'b0100,
		PH_ERR_E  = 4'b1000
	} phase_t;

	localparam logic [7:0] ERR_LEAD  = 8'hC2;
	localparam logic [7:0] ERR_E     = 8'h45;
	localparam logic [7:0] ERR_R     = 8'h52;
	localparam int         START_BIT = 7;
	localparam int         DIST_W    = 21;
	localparam int         LEN_W     = 4;
	localparam logic [LEN_W-1:0] MIN_LEN   = 4'd3;
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd3;

	// Result of one byte through the framer
	typedef struct packed {
		logic              hit;
		logic              error_flag;
		logic [DIST_W-1:0] distance;
	} result_t;

endpackage

// ----- rtl/core/range_meter_binary_packet_parser.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// rx        rx_valid / rx_stall    rx_byte[7:0]
// res       res_valid / res_stall  error_flag, distance[20:0]
// cfg       cfg_wen                cfg_wdata[3:0] (packet_length)
//
// One byte per cycle, unless a stalled result holds the input stage.
// The byte goes through one input stage, then the framer updates its phase and
// loads the output register in a single pass.
// arst_n clears the phase, byte count, stage and output valid; packet_length -> 3.
// A waiting result holds the stage only when the staged byte also has a result.

module range_meter_binary_packet_parser #(
	parameter int MAX_PACKET_BYTES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rx_valid,
	output logic                              rx_stall,
	input  logic [7:0]                        rx_byte,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              error_flag,
	output logic [rmbpp_pkg::DIST_W-1:0]      distance,
	input  logic                              cfg_wen,
	input  logic [rmbpp_pkg::LEN_W-1:0]       cfg_wdata
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic [rmbpp_pkg::LEN_W-1:0] packet_length_q;
	logic                        res_valid_q;
	logic                        error_q;
	logic [rmbpp_pkg::DIST_W-1:0] distance_q;
	logic                        out_free;
	logic                        advance;
	logic                        rx_take;
	rmbpp_pkg::result_t          result;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= rmbpp_pkg::LEN_RESET;
		end else if (cfg_wen) begin
			packet_length_q <= cfg_wdata;
		end
	end

	// Stage advance: a byte with no result never waits on the output
	assign out_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && (!result.hit || out_free);
	assign rx_stall = valid_s1 && !advance;
	assign rx_take  = rx_valid && !rx_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) byte_s1 <= rx_byte;
	end

	rmbpp_framer #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.rx_byte      (byte_s1),
		.packet_length(packet_length_q),
		.result       (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && result.hit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.hit) begin
			error_q    <= result.error_flag;
			distance_q <= result.distance;
		end
	end

	assign res_valid  = res_valid_q;
	assign error_flag = error_q;
	assign distance   = distance_q;

	// A stalled input means the stage holds a byte that has a result to deliver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && result.hit && res_valid_q && res_stall))
		else $error("input stalled without a blocked result");

	// Error reports carry a zero distance
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && error_flag) |-> (distance == '0))
		else $error("error result with nonzero distance");

	// A stalled result transaction stays valid and unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=>
		(res_valid && $stable(error_flag) && $stable(distance)))
		else $error("stalled result changed");

endmodule

// ----- rtl/core/rmbpp_framer.sv -----
`timescale 1ns / 1ps

module rmbpp_framer #(
	parameter int MAX_PACKET_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [7:0]                     rx_byte,
	input  logic [rmbpp_pkg::LEN_W-1:0]    packet_length,
	output rmbpp_pkg::result_t             result
);

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int LW    = (CNT_W > rmbpp_pkg::LEN_W) ? CNT_W : rmbpp_pkg::LEN_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PACKET_BYTES);

	rmbpp_pkg::phase_t phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [6:0]        b0_q;
	logic [7:0]        b1_q;
	logic [6:0]        b2_q;
	logic              wr_b0, wr_b1, wr_b2;

	logic [rmbpp_pkg::LEN_W-1:0] len_min;
	logic [LW-1:0]               eff_len;
	logic [LW-1:0]               count_inc;
	logic [6:0]                  b2_use;

	// Clamp the configured length to [3, MAX_PACKET_BYTES]
	always_comb begin
		len_min = (packet_length < rmbpp_pkg::MIN_LEN) ? rmbpp_pkg::MIN_LEN : packet_length;
		eff_len = (LW'(len_min) > MAX_LEN) ? MAX_LEN : LW'(len_min);
	end

	assign count_inc = LW'(count_q) + LW'(1);
	// the third byte may be arriving in this very transaction
	assign b2_use    = (count_q == CNT_W'(2)) ? rx_byte[6:0] : b2_q;

	// Next phase, byte capture and result
	always_comb begin
		phase_d           = phase_q;
		count_d           = count_q;
		wr_b0             = 1'b0;
		wr_b1             = 1'b0;
		wr_b2             = 1'b0;
		result.hit        = 1'b0;
		result.error_flag = 1'b0;
		result.distance   = {6'd0, b1_q, 7'd0} | {b0_q, 14'd0} | {14'd0, b2_use};
		case (phase_q)
			rmbpp_pkg::PH_WAIT: begin
				count_d = '0;
				if (rx_byte == rmbpp_pkg::ERR_LEAD) begin
					phase_d = rmbpp_pkg::PH_ERR_C2;
				end else if (rx_byte[rmbpp_pkg::START_BIT]) begin
					wr_b0   = 1'b1;
					count_d = CNT_W'(1);
					phase_d = rmbpp_pkg::PH_DATA;
				end
			end
			rmbpp_pkg::PH_ERR_C2: begin
				phase_d = (rx_byte == rmbpp_pkg::ERR_E) ? rmbpp_pkg::PH_ERR_E
				                                        : rmbpp_pkg::PH_WAIT;
			end
			rmbpp_pkg::PH_ERR_E: begin
				phase_d = rmbpp_pkg::PH_WAIT;
				if (rx_byte == rmbpp_pkg::ERR_R) begin
					result.hit        = 1'b1;
					result.error_flag = 1'b1;
					result.distance   = '0;
				end
			end
			rmbpp_pkg::PH_DATA: begin
				wr_b1   = (count_q == CNT_W'(1));
				wr_b2   = (count_q == CNT_W'(2));
				count_d = count_inc[CNT_W-1:0];
				if (count_inc >= eff_len) begin
					phase_d    = rmbpp_pkg::PH_WAIT;
					count_d    = '0;
					result.hit = 1'b1;
				end
			end
			default: begin
				phase_d = rmbpp_pkg::PH_WAIT;
				count_d = '0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rmbpp_pkg::PH_WAIT;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// Packet bytes, written before they are read
	always_ff @(posedge clk) begin
		if (advance && wr_b0) b0_q <= rx_byte[6:0];
		if (advance && wr_b1) b1_q <= rx_byte;
		if (advance && wr_b2) b2_q <= rx_byte[6:0];
	end

	// Count is only live inside a packet
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != rmbpp_pkg::PH_DATA) |-> (count_q == '0))
		else $error("byte count nonzero outside a packet");

	// Error report only closes a C2 'E' 'R' sequence
	a_err_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.hit && result.error_flag) |->
		(phase_q == rmbpp_pkg::PH_ERR_E && rx_byte == rmbpp_pkg::ERR_R))
		else $error("error report outside error sequence");

	// Any result returns the framer to waiting
	a_hit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.hit) |=> (phase_q == rmbpp_pkg::PH_WAIT && count_q == '0))
		else $error("framer not back to waiting after a result");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_BYTES  = 8;
	localparam int SETTLE     = 6;
	localparam int HOLD_LEN   = 150;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASES     = 8;
	localparam int PER_PHASE  = 195;

	// Expected transaction on the result channel
	typedef struct packed {
		logic                         error_flag;
		logic [rmbpp_pkg::DIST_W-1:0] distance;
	} reading_t;

	// Opening bytes: extremes, error sequences, broken ones, strays, lead byte in data
	localparam logic [7:0] OPENING [22] = '{
		8'hFF, 8'hFF, 8'hFF,
		8'h80, 8'h00, 8'h00,
		rmbpp_pkg::ERR_LEAD, rmbpp_pkg::ERR_E, rmbpp_pkg::ERR_R,
		rmbpp_pkg::ERR_LEAD, rmbpp_pkg::ERR_E, 8'h80,
		rmbpp_pkg::ERR_LEAD, 8'h90,
		8'h05,
		8'h81, rmbpp_pkg::ERR_LEAD, 8'hFF,
		rmbpp_pkg::ERR_LEAD, rmbpp_pkg::ERR_LEAD, rmbpp_pkg::ERR_E,
		8'h7F
	};

	localparam logic [rmbpp_pkg::LEN_W-1:0] LEN_PLAN [PHASES] = '{
		4'd0, 4'd3, 4'd4, 4'd8, 4'd15, 4'd5, 4'd3, 4'd8
	};
	localparam int SEND_IDLE [4] = '{0, 70, 0, 36};
	localparam int RECV_STALL [4] = '{0, 0, 70, 36};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         rx_valid = 1'b0;
	logic                         rx_stall;
	logic [7:0]                   rx_byte = 8'h00;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	logic                         error_flag;
	logic [rmbpp_pkg::DIST_W-1:0] distance;
	logic                         cfg_wen = 1'b0;
	logic [rmbpp_pkg::LEN_W-1:0]  cfg_wdata = rmbpp_pkg::LEN_RESET;

	// Bytes waiting to be offered, and readings waiting to come out
	logic [7:0] rx_backlog [$];
	reading_t   expected_readings [$];

	// Parser state as the testbench sees it
	rmbpp_pkg::phase_t           frame_phase = rmbpp_pkg::PH_WAIT;
	logic [3:0]                  frame_count = '0;
	logic [7:0]                  frame_bytes [3] = '{8'h00, 8'h00, 8'h00};
	logic [rmbpp_pkg::LEN_W-1:0] meter_len = rmbpp_pkg::LEN_RESET;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int phase_no = 0;
	int seen_phase = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycles = 0;

	range_meter_binary_packet_parser #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.error_flag(error_flag),
		.distance(distance),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Packet length after clamping to 3..MAX_BYTES
	function automatic int packet_bytes_needed();
		if (meter_len < rmbpp_pkg::MIN_LEN)
			return rmbpp_pkg::MIN_LEN;
		if (meter_len > MAX_BYTES)
			return MAX_BYTES;
		return meter_len;
	endfunction

	// Advance the framer by one accepted byte; queue a reading when one completes
	task automatic frame_byte(input logic [7:0] b);
		int       n;
		reading_t r;
		case (frame_phase)
			rmbpp_pkg::PH_WAIT: begin
				frame_count = '0;
				if (b == rmbpp_pkg::ERR_LEAD) begin
					frame_phase = rmbpp_pkg::PH_ERR_C2;
				end else if (b[rmbpp_pkg::START_BIT]) begin
					frame_bytes[0] = {1'b0, b[6:0]};
					frame_count = 4'd1;
					frame_phase = rmbpp_pkg::PH_DATA;
				end
			end
			rmbpp_pkg::PH_ERR_C2: frame_phase = (b == rmbpp_pkg::ERR_E) ?
				rmbpp_pkg::PH_ERR_E : rmbpp_pkg::PH_WAIT;
			rmbpp_pkg::PH_ERR_E: begin
				frame_phase = rmbpp_pkg::PH_WAIT;
				if (b == rmbpp_pkg::ERR_R) begin
					r.error_flag = 1'b1;
					r.distance = '0;
					expected_readings.push_back(r);
				end
			end
			default: begin
				// collecting: every byte is data, only the first three are kept
				n = frame_count;
				if (n < 3)
					frame_bytes[n] = b;
				n++;
				if (n > 15)
					n = 15;
				frame_count = n[3:0];
				if (n >= packet_bytes_needed()) begin
					frame_phase = rmbpp_pkg::PH_WAIT;
					r.error_flag = 1'b0;
					r.distance = (rmbpp_pkg::DIST_W'(frame_bytes[0][6:0]) << 14)
						| (rmbpp_pkg::DIST_W'(frame_bytes[1]) << 7)
						| rmbpp_pkg::DIST_W'(frame_bytes[2][6:0]);
					expected_readings.push_back(r);
				end
			end
		endcase
	endtask

	// Random traffic: mostly packets and error sequences, some broken ones and noise
	task automatic queue_traffic(input int n);
		int         base;
		int         pick;
		int         body;
		logic [7:0] b;
		base = rx_backlog.size();
		while (rx_backlog.size() - base < n) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				rx_backlog.push_back(8'($urandom_range(128, 255)));
				body = packet_bytes_needed() - 1;
				// now and then a packet that is cut short or runs over
				if ($urandom_range(9) == 0)
					body = $urandom_range(0, 9);
				repeat (body)
					rx_backlog.push_back(8'($urandom_range(255)));
			end else if (pick < 72) begin
				rx_backlog.push_back(rmbpp_pkg::ERR_LEAD);
				rx_backlog.push_back(rmbpp_pkg::ERR_E);
				rx_backlog.push_back(rmbpp_pkg::ERR_R);
			end else if (pick < 82) begin
				rx_backlog.push_back(rmbpp_pkg::ERR_LEAD);
				b = 8'($urandom_range(255));
				if ($urandom_range(1)) begin
					rx_backlog.push_back(rmbpp_pkg::ERR_E);
					if (b == rmbpp_pkg::ERR_R)
						b = 8'h00;
				end else if (b == rmbpp_pkg::ERR_E) begin
					b = 8'hFF;
				end
				rx_backlog.push_back(b);
			end else begin
				rx_backlog.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Wait until every byte is taken and every reading is out, then let the pipe settle
	task automatic drain();
		do
			@(negedge clk);
		while (rx_backlog.size() != 0 || rx_valid || expected_readings.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_length(input logic [rmbpp_pkg::LEN_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		meter_len = v;
	endtask

	// Sequence: reset, opening bytes, then one phase per length setting
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (OPENING[i])
			rx_backlog.push_back(OPENING[i]);
		drain();
		for (int p = 0; p < PHASES; p++) begin
			write_length(LEN_PLAN[p]);
			@(negedge clk);
			send_idle_pct = SEND_IDLE[p % 4];
			stall_pct = RECV_STALL[p % 4];
			phase_no = p + 1;
			queue_traffic(PER_PHASE);
			drain();
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Driver: one byte per transaction, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				frame_byte(rx_byte);
			if (!rx_valid || !rx_stall) begin
				if (rx_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_valid <= 1'b1;
					rx_byte <= rx_backlog.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expected reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected result: error_flag %0d distance %0d", error_flag,
						distance);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					if (error_flag !== want.error_flag) begin
						$error("error_flag: expected %0d, got %0d", want.error_flag,
							error_flag);
						mismatches++;
					end
					if (distance !== want.distance) begin
						$error("distance: expected %0d, got %0d", want.distance, distance);
						mismatches++;
					end
				end
			end
		end
	end

	// Receiver stall: long hold-off at the start of odd phases so the input backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (phase_no != seen_phase) begin
				seen_phase <= phase_no;
				if (phase_no % 2 == 1) begin
					res_stall <= 1'b1;
					hold_left <= HOLD_LEN;
				end else begin
					res_stall <= ($urandom_range(99) < stall_pct);
				end
			end else if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// ----- files.f -----
rtl/core/rmbpp_pkg.sv
rtl/core/rmbpp_framer.sv
rtl/core/range_meter_binary_packet_parser.sv
tb/testbench.sv
